// ----- hw/rtl/lpsf_pkg.sv -----
package lpsf_pkg;

    // Fraction bits of the fixed point coordinates and ranges
    localparam int COORD_FRAC_BITS = 16;

    localparam int COORD_W    = 32;
    localparam int RANGE_W    = 31;
    localparam int CNT_W      = 8;
    localparam int LINE_W     = 8;
    localparam int TAG_W      = 8;
    localparam int REFL_W     = 8;
    localparam int STAMP_W    = 64;
    localparam int OFFS_W     = 32;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int BOUND_W    = 2 * RANGE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RANGE_W;

    // Reset values: 0.5 m and 300 m (clipped to the register width)
    localparam logic [63:0] RANGE_LIMIT   = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] MAX_RANGE_RAW = 64'd300 << COORD_FRAC_BITS;
    localparam logic [RANGE_W-1:0] MIN_RANGE_RST =
        RANGE_W'(64'd1 << (COORD_FRAC_BITS - 1));
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST =
        RANGE_W'((MAX_RANGE_RAW > RANGE_LIMIT) ? RANGE_LIMIT : MAX_RANGE_RAW);
    localparam logic [CNT_W-1:0]  DECIMATION_RST = CNT_W'(2);
    localparam logic [LINE_W-1:0] LINE_COUNT_RST = LINE_W'(6);

    // Return quality field of the tag byte
    localparam logic [TAG_W-1:0] TAG_QUALITY_MASK = 8'h30;
    localparam logic [TAG_W-1:0] TAG_QUALITY_OK0  = 8'h00;
    localparam logic [TAG_W-1:0] TAG_QUALITY_OK1  = 8'h10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RANGE  = 2'd0,
        CFG_MAX_RANGE  = 2'd1,
        CFG_DECIMATION = 2'd2,
        CFG_LINE_COUNT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [RANGE_W-1:0] min_range;
        logic [RANGE_W-1:0] max_range;
        logic [CNT_W-1:0]   decimation;
        logic [LINE_W-1:0]  line_count;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [REFL_W-1:0]         refl;
        logic [OFFS_W-1:0]         offset;
    } t_point;

endpackage

// ----- hw/rtl/lidar_point_stream_filter.sv -----
// Channel  Valid          Stall          Payload
// input    i_in_valid     o_in_stall     i_frame_start, i_pos_x/y/z, i_reflectivity,
//                                        i_stamp_ns, i_scan_line, i_tag_bits
// output   o_out_valid    i_out_stall    o_out_x/y/z, o_out_reflectivity, o_time_offset_ns
// config   i_cfg_we       (none)         i_cfg_index, i_cfg_data
//
// One point per cycle while no stall backs up; a kept point passes the front stage, square and result registers.
// Frame state (time base, decimation counter, previous slot) updates at transfer.
// Squares of coordinates and bounds are registered before the window compare.
// Reset is synchronous, active low; valid and frame state clear, configuration registers take reset values.
// An output stall holds the result and backs up through the pipeline to o_in_stall.
module lidar_point_stream_filter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lpsf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lpsf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_frame_start,
    input  logic signed [lpsf_pkg::COORD_W-1:0]  i_pos_x,
    input  logic signed [lpsf_pkg::COORD_W-1:0]  i_pos_y,
    input  logic signed [lpsf_pkg::COORD_W-1:0]  i_pos_z,
    input  logic [lpsf_pkg::REFL_W-1:0]          i_reflectivity,
    input  logic [lpsf_pkg::STAMP_W-1:0]         i_stamp_ns,
    input  logic [lpsf_pkg::LINE_W-1:0]          i_scan_line,
    input  logic [lpsf_pkg::TAG_W-1:0]           i_tag_bits,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [lpsf_pkg::COORD_W-1:0]  o_out_x,
    output logic signed [lpsf_pkg::COORD_W-1:0]  o_out_y,
    output logic signed [lpsf_pkg::COORD_W-1:0]  o_out_z,
    output logic [lpsf_pkg::REFL_W-1:0]          o_out_reflectivity,
    output logic [lpsf_pkg::OFFS_W-1:0]          o_time_offset_ns
);

    lpsf_pkg::t_cfg   w_cfg;
    lpsf_pkg::t_point w_point;
    logic             w_valid;
    logic             w_ready;

    // Configuration registers
    lpsf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Qualification, decimation and frame state
    lpsf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_frame_start  (i_frame_start),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_reflectivity (i_reflectivity),
        .i_stamp_ns     (i_stamp_ns),
        .i_scan_line    (i_scan_line),
        .i_tag_bits     (i_tag_bits),
        .o_valid        (w_valid),
        .i_ready        (w_ready),
        .o_point        (w_point)
    );

    // Range window and result register
    lpsf_range u_range (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (w_cfg),
        .i_valid            (w_valid),
        .o_ready            (w_ready),
        .i_point            (w_point),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_x            (o_out_x),
        .o_out_y            (o_out_y),
        .o_out_z            (o_out_z),
        .o_out_reflectivity (o_out_reflectivity),
        .o_time_offset_ns   (o_time_offset_ns)
    );

endmodule

// ----- hw/rtl/lpsf_cfg_regs.sv -----
module lpsf_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lpsf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lpsf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output lpsf_pkg::t_cfg                   o_cfg
);

    lpsf_pkg::t_cfg r_cfg;
    lpsf_pkg::t_cfg n_cfg;

    // Decode the register write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (lpsf_pkg::t_cfg_idx'(i_cfg_index))
                lpsf_pkg::CFG_MIN_RANGE:  n_cfg.min_range  = i_cfg_data;
                lpsf_pkg::CFG_MAX_RANGE:  n_cfg.max_range  = i_cfg_data;
                lpsf_pkg::CFG_DECIMATION: n_cfg.decimation = i_cfg_data[lpsf_pkg::CNT_W-1:0];
                lpsf_pkg::CFG_LINE_COUNT: n_cfg.line_count = i_cfg_data[lpsf_pkg::LINE_W-1:0];
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_range  <= lpsf_pkg::MIN_RANGE_RST;
            r_cfg.max_range  <= lpsf_pkg::MAX_RANGE_RST;
            r_cfg.decimation <= lpsf_pkg::DECIMATION_RST;
            r_cfg.line_count <= lpsf_pkg::LINE_COUNT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/lpsf_front.sv -----
module lpsf_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lpsf_pkg::t_cfg                        i_cfg,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_frame_start,
    input  logic signed [lpsf_pkg::COORD_W-1:0]   i_pos_x,
    input  logic signed [lpsf_pkg::COORD_W-1:0]   i_pos_y,
    input  logic signed [lpsf_pkg::COORD_W-1:0]   i_pos_z,
    input  logic [lpsf_pkg::REFL_W-1:0]           i_reflectivity,
    input  logic [lpsf_pkg::STAMP_W-1:0]          i_stamp_ns,
    input  logic [lpsf_pkg::LINE_W-1:0]           i_scan_line,
    input  logic [lpsf_pkg::TAG_W-1:0]            i_tag_bits,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output lpsf_pkg::t_point                      o_point
);

    logic [lpsf_pkg::STAMP_W-1:0]        r_time_base;
    logic [lpsf_pkg::STAMP_W-1:0]        n_time_base;
    logic [lpsf_pkg::CNT_W-1:0]          r_count;
    logic [lpsf_pkg::CNT_W-1:0]          n_count;
    logic signed [lpsf_pkg::COORD_W-1:0] r_prev_x;
    logic signed [lpsf_pkg::COORD_W-1:0] r_prev_y;
    logic signed [lpsf_pkg::COORD_W-1:0] r_prev_z;
    logic signed [lpsf_pkg::COORD_W-1:0] n_prev_x;
    logic signed [lpsf_pkg::COORD_W-1:0] n_prev_y;
    logic signed [lpsf_pkg::COORD_W-1:0] n_prev_z;
    logic                                r_valid;
    lpsf_pkg::t_point                    r_point;

    logic                                w_fire;
    logic                                w_line_ok;
    logic                                w_tag_ok;
    logic                                w_qual;
    logic [lpsf_pkg::TAG_W-1:0]          w_quality;
    logic [lpsf_pkg::CNT_W-1:0]          w_n;
    logic [lpsf_pkg::CNT_W-1:0]          w_cnt_inc;
    logic                                w_keep;
    logic                                w_dup;
    logic                                w_cand;
    logic [lpsf_pkg::STAMP_W:0]          w_diff;
    logic [lpsf_pkg::OFFS_W-1:0]         w_offset;

    // Transfer on the input side when the stage register is free or drains
    assign o_in_stall = r_valid && !i_ready;
    assign w_fire     = i_in_valid && !o_in_stall;

    // Qualify the point: scan line, return quality, decimation
    assign w_line_ok = i_scan_line < i_cfg.line_count;
    assign w_quality = i_tag_bits & lpsf_pkg::TAG_QUALITY_MASK;
    assign w_tag_ok  = (w_quality == lpsf_pkg::TAG_QUALITY_OK0) ||
                       (w_quality == lpsf_pkg::TAG_QUALITY_OK1);
    assign w_qual    = w_line_ok && w_tag_ok;
    assign w_n       = (i_cfg.decimation == '0) ? lpsf_pkg::CNT_W'(1) : i_cfg.decimation;
    assign w_cnt_inc = r_count + lpsf_pkg::CNT_W'(1);
    assign w_keep    = w_qual && (w_cnt_inc >= w_n);

    // Compare against the previous slot before it is overwritten
    assign w_dup  = (i_pos_x == r_prev_x) && (i_pos_y == r_prev_y) && (i_pos_z == r_prev_z);
    assign w_cand = !i_frame_start && w_keep && !w_dup;

    // Time offset from the frame base, clamped to zero and to 32 bits
    assign w_diff = {1'b0, i_stamp_ns} - {1'b0, r_time_base};
    always_comb begin
        if (w_diff[lpsf_pkg::STAMP_W]) begin
            w_offset = '0;
        end else if (|w_diff[lpsf_pkg::STAMP_W-1:lpsf_pkg::OFFS_W]) begin
            w_offset = '1;
        end else begin
            w_offset = w_diff[lpsf_pkg::OFFS_W-1:0];
        end
    end

    // Frame state update
    always_comb begin
        n_time_base = r_time_base;
        n_count     = r_count;
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        n_prev_z    = r_prev_z;
        if (w_fire) begin
            if (i_frame_start) begin
                n_time_base = i_stamp_ns;
                n_count     = '0;
                n_prev_x    = '0;
                n_prev_y    = '0;
                n_prev_z    = '0;
            end else begin
                if (w_qual) begin
                    n_count = w_keep ? '0 : w_cnt_inc;
                end
                n_prev_x = w_keep ? i_pos_x : '0;
                n_prev_y = w_keep ? i_pos_y : '0;
                n_prev_z = w_keep ? i_pos_z : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_base <= '0;
            r_count     <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_time_base <= n_time_base;
            r_count     <= n_count;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
            r_prev_z    <= n_prev_z;
            if (w_fire) begin
                r_valid <= w_cand;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Capture the candidate payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_point.x      <= i_pos_x;
            r_point.y      <= i_pos_y;
            r_point.z      <= i_pos_z;
            r_point.refl   <= i_reflectivity;
            r_point.offset <= w_offset;
        end
    end

    assign o_valid = r_valid;
    assign o_point = r_point;

`ifndef SYNTH
    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_frame_start |=>
            r_count == '0 && r_prev_x == '0 && r_prev_y == '0 && r_prev_z == '0)
        else $error("frame start did not clear counter and previous slot");

    a_reject_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && !i_frame_start && !w_qual |=>
            r_count == $past(r_count) && r_prev_x == '0 && r_prev_y == '0 && r_prev_z == '0)
        else $error("rejected point changed counter or left previous slot set");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_point))
        else $error("candidate lost while downstream busy");
`endif

endmodule

// ----- hw/rtl/lpsf_range.sv -----
module lpsf_range (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lpsf_pkg::t_cfg                       i_cfg,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  lpsf_pkg::t_point                     i_point,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [lpsf_pkg::COORD_W-1:0]  o_out_x,
    output logic signed [lpsf_pkg::COORD_W-1:0]  o_out_y,
    output logic signed [lpsf_pkg::COORD_W-1:0]  o_out_z,
    output logic [lpsf_pkg::REFL_W-1:0]          o_out_reflectivity,
    output logic [lpsf_pkg::OFFS_W-1:0]          o_time_offset_ns
);

    function automatic logic [lpsf_pkg::COORD_W-1:0] abs_mag(
        input logic [lpsf_pkg::COORD_W-1:0] v
    );
        return v[lpsf_pkg::COORD_W-1] ? (~v + lpsf_pkg::COORD_W'(1)) : v;
    endfunction

    logic                             r_sq_valid;
    logic [lpsf_pkg::SQ_W-1:0]        r_sq_x;
    logic [lpsf_pkg::SQ_W-1:0]        r_sq_y;
    logic [lpsf_pkg::SQ_W-1:0]        r_sq_z;
    logic [lpsf_pkg::BOUND_W-1:0]     r_lo;
    logic [lpsf_pkg::BOUND_W-1:0]     r_hi;
    lpsf_pkg::t_point                 r_sq_point;
    logic                             r_out_valid;
    lpsf_pkg::t_point                 r_out_point;

    logic [lpsf_pkg::COORD_W-1:0]  w_mag_x;
    logic [lpsf_pkg::COORD_W-1:0]  w_mag_y;
    logic [lpsf_pkg::COORD_W-1:0]  w_mag_z;
    logic [lpsf_pkg::SQ_W-1:0]     w_dist;
    logic                          w_in_range;
    logic                          w_adv_out;

    // Advance the output register when empty or taken
    assign w_adv_out = !r_out_valid || !i_out_stall;
    assign o_ready   = !r_sq_valid || w_adv_out;

    assign w_mag_x = abs_mag(i_point.x);
    assign w_mag_y = abs_mag(i_point.y);
    assign w_mag_z = abs_mag(i_point.z);

    // Square the magnitudes and the range bounds
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_sq_x     <= lpsf_pkg::SQ_W'(w_mag_x) * lpsf_pkg::SQ_W'(w_mag_x);
            r_sq_y     <= lpsf_pkg::SQ_W'(w_mag_y) * lpsf_pkg::SQ_W'(w_mag_y);
            r_sq_z     <= lpsf_pkg::SQ_W'(w_mag_z) * lpsf_pkg::SQ_W'(w_mag_z);
            r_lo       <= lpsf_pkg::BOUND_W'(i_cfg.min_range) *
                          lpsf_pkg::BOUND_W'(i_cfg.min_range);
            r_hi       <= lpsf_pkg::BOUND_W'(i_cfg.max_range) *
                          lpsf_pkg::BOUND_W'(i_cfg.max_range);
            r_sq_point <= i_point;
        end
    end

    // Sum the squares and test the window, inclusive at both ends
    assign w_dist     = r_sq_x + r_sq_y + r_sq_z;
    assign w_in_range = (w_dist >= lpsf_pkg::SQ_W'(r_lo)) && (w_dist <= lpsf_pkg::SQ_W'(r_hi));

    always_ff @(posedge i_clk) begin
        if (w_adv_out) begin
            r_out_point <= r_sq_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_sq_valid <= i_valid;
            end
            if (w_adv_out) begin
                r_out_valid <= r_sq_valid && w_in_range;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_x            = r_out_point.x;
    assign o_out_y            = r_out_point.y;
    assign o_out_z            = r_out_point.z;
    assign o_out_reflectivity = r_out_point.refl;
    assign o_time_offset_ns   = r_out_point.offset;

`ifndef SYNTH
    a_window_decides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_valid && w_adv_out |=> r_out_valid == $past(w_in_range))
        else $error("output valid does not follow the range window");

    a_empty_gives_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sq_valid && w_adv_out |=> !r_out_valid)
        else $error("result produced from an empty stage");
`endif

endmodule

// ----- bench/testbench.sv -----
module testbench;

    typedef struct packed {
        logic                                frame_start;
        logic signed [lpsf_pkg::COORD_W-1:0] pos_x;
        logic signed [lpsf_pkg::COORD_W-1:0] pos_y;
        logic signed [lpsf_pkg::COORD_W-1:0] pos_z;
        logic [lpsf_pkg::REFL_W-1:0]         refl;
        logic [lpsf_pkg::STAMP_W-1:0]        stamp;
        logic [lpsf_pkg::LINE_W-1:0]         line_idx;
        logic [lpsf_pkg::TAG_W-1:0]          tag;
    } t_point_in;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT      = 50000;
    localparam int SETTLE_CYCLES    = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Configuration port
    logic                            cfg_we    = 1'b0;
    lpsf_pkg::t_cfg_idx              cfg_index = lpsf_pkg::CFG_MIN_RANGE;
    logic [lpsf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Point input and result output channels
    logic      in_valid  = 1'b0;
    t_point_in cur       = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    logic signed [lpsf_pkg::COORD_W-1:0] o_out_x;
    logic signed [lpsf_pkg::COORD_W-1:0] o_out_y;
    logic signed [lpsf_pkg::COORD_W-1:0] o_out_z;
    logic [lpsf_pkg::REFL_W-1:0]         o_out_reflectivity;
    logic [lpsf_pkg::OFFS_W-1:0]         o_time_offset_ns;

    // Filter settings as last written
    logic [lpsf_pkg::RANGE_W-1:0] cfg_min   = lpsf_pkg::MIN_RANGE_RST;
    logic [lpsf_pkg::RANGE_W-1:0] cfg_max   = lpsf_pkg::MAX_RANGE_RST;
    logic [lpsf_pkg::CNT_W-1:0]   cfg_decim = lpsf_pkg::DECIMATION_RST;
    logic [lpsf_pkg::LINE_W-1:0]  cfg_lines = lpsf_pkg::LINE_COUNT_RST;

    // Frame state of the filter
    logic [lpsf_pkg::STAMP_W-1:0]        frame_base  = '0;
    logic [lpsf_pkg::CNT_W-1:0]          decim_count = '0;
    logic signed [lpsf_pkg::COORD_W-1:0] slot_x      = '0;
    logic signed [lpsf_pkg::COORD_W-1:0] slot_y      = '0;
    logic signed [lpsf_pkg::COORD_W-1:0] slot_z      = '0;

    t_point_in        pending[$];
    lpsf_pkg::t_point kept_points[$];
    int               n_errors = 0;

    // Sender and receiver pacing
    bit               tx_holding = 1'b0;
    bit               tx_burst   = 1'b0;
    int unsigned      tx_wait    = 0;
    bit               rx_burst   = 1'b0;
    int unsigned      rx_left    = 0;
    int unsigned      hold_left  = 0;
    int               long_hold_req = 0;
    int               long_hold_ack = 0;
    lpsf_pkg::t_point predicted;
    lpsf_pkg::t_point want;

    // Stimulus state
    logic [lpsf_pkg::STAMP_W-1:0] stamp_now = '0;
    t_point_in                    last_pt   = '0;

    lidar_point_stream_filter DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (o_in_stall),
        .i_frame_start      (cur.frame_start),
        .i_pos_x            (cur.pos_x),
        .i_pos_y            (cur.pos_y),
        .i_pos_z            (cur.pos_z),
        .i_reflectivity     (cur.refl),
        .i_stamp_ns         (cur.stamp),
        .i_scan_line        (cur.line_idx),
        .i_tag_bits         (cur.tag),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (out_stall),
        .o_out_x            (o_out_x),
        .o_out_y            (o_out_y),
        .o_out_z            (o_out_z),
        .o_out_reflectivity (o_out_reflectivity),
        .o_time_offset_ns   (o_time_offset_ns)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Exact square of a signed coordinate; the most negative value squares to 2^62
    function automatic logic [lpsf_pkg::SQ_W-1:0] coord_sq(
        input logic signed [lpsf_pkg::COORD_W-1:0] v
    );
        logic [lpsf_pkg::COORD_W:0] mag;
        mag = v[lpsf_pkg::COORD_W-1] ? -{v[lpsf_pkg::COORD_W-1], v} : {1'b0, v};
        return lpsf_pkg::SQ_W'(mag) * lpsf_pkg::SQ_W'(mag);
    endfunction

    // Advance the frame state by one point; return 1 when the point is kept
    function automatic bit filter_point(input t_point_in p, output lpsf_pkg::t_point kept);
        logic signed [lpsf_pkg::COORD_W-1:0] old_x, old_y, old_z;
        logic [lpsf_pkg::CNT_W-1:0]          every_n;
        logic [lpsf_pkg::SQ_W-1:0]           range_sq, lo, hi;
        logic [lpsf_pkg::STAMP_W-1:0]        delta;
        logic [lpsf_pkg::TAG_W-1:0]          quality;
        kept  = '0;
        old_x = slot_x;
        old_y = slot_y;
        old_z = slot_z;
        slot_x = '0;
        slot_y = '0;
        slot_z = '0;
        if (p.frame_start) begin
            frame_base  = p.stamp;
            decim_count = '0;
            return 1'b0;
        end
        if (p.line_idx >= cfg_lines)
            return 1'b0;
        quality = p.tag & lpsf_pkg::TAG_QUALITY_MASK;
        if (quality != lpsf_pkg::TAG_QUALITY_OK0 && quality != lpsf_pkg::TAG_QUALITY_OK1)
            return 1'b0;
        every_n = (cfg_decim == '0) ? lpsf_pkg::CNT_W'(1) : cfg_decim;
        decim_count = decim_count + lpsf_pkg::CNT_W'(1);
        if (decim_count < every_n)
            return 1'b0;
        decim_count = '0;
        slot_x = p.pos_x;
        slot_y = p.pos_y;
        slot_z = p.pos_z;
        range_sq = coord_sq(p.pos_x) + coord_sq(p.pos_y) + coord_sq(p.pos_z);
        lo       = lpsf_pkg::SQ_W'(cfg_min) * lpsf_pkg::SQ_W'(cfg_min);
        hi       = lpsf_pkg::SQ_W'(cfg_max) * lpsf_pkg::SQ_W'(cfg_max);
        if (range_sq < lo || range_sq > hi)
            return 1'b0;
        if (p.pos_x == old_x && p.pos_y == old_y && p.pos_z == old_z)
            return 1'b0;
        delta = (p.stamp < frame_base) ? '0 : p.stamp - frame_base;
        if (delta > lpsf_pkg::STAMP_W'(32'hFFFF_FFFF))
            delta = lpsf_pkg::STAMP_W'(32'hFFFF_FFFF);
        kept.x      = p.pos_x;
        kept.y      = p.pos_y;
        kept.z      = p.pos_z;
        kept.refl   = p.refl;
        kept.offset = delta[lpsf_pkg::OFFS_W-1:0];
        return 1'b1;
    endfunction

    // Append a point to the driver queue
    task automatic queue_point(input t_point_in p);
        pending.insert(pending.size(), p);
    endtask

    // Driver: offer queued points, predict each one at its transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                if (filter_point(cur, predicted))
                    kept_points.insert(kept_points.size(), predicted);
                tx_holding = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    tx_burst = !tx_burst;
                tx_wait = tx_burst ? 0 : $urandom_range(0, 17);
            end
            if (!tx_holding) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end else if (pending.size() > 0) begin
                    cur        <= pending.pop_front();
                    tx_holding = 1'b1;
                    in_valid   <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest kept point
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (kept_points.size() == 0) begin
                    $error("unexpected point: x %h y %h z %h", o_out_x, o_out_y, o_out_z);
                    n_errors++;
                end else begin
                    want = kept_points.pop_front();
                    if (o_out_x !== want.x) begin
                        $error("out_x: expected %h, got %h", want.x, o_out_x);
                        n_errors++;
                    end
                    if (o_out_y !== want.y) begin
                        $error("out_y: expected %h, got %h", want.y, o_out_y);
                        n_errors++;
                    end
                    if (o_out_z !== want.z) begin
                        $error("out_z: expected %h, got %h", want.z, o_out_z);
                        n_errors++;
                    end
                    if (o_out_reflectivity !== want.refl) begin
                        $error("out_reflectivity: expected %h, got %h",
                               want.refl, o_out_reflectivity);
                        n_errors++;
                    end
                    if (o_time_offset_ns !== want.offset) begin
                        $error("time_offset_ns: expected %h, got %h",
                               want.offset, o_time_offset_ns);
                        n_errors++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    rx_burst = !rx_burst;
                rx_left = rx_burst ? 0 : $urandom_range(0, 17);
            end
            // Start a long hold when asked, so the pipeline backs up
            if (long_hold_ack != long_hold_req) begin
                long_hold_ack = long_hold_req;
                hold_left     = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (rx_left > 0) begin
                rx_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic t_point_in mk_point(input bit fs,
                                           input logic signed [lpsf_pkg::COORD_W-1:0] x, y, z,
                                           input logic [lpsf_pkg::REFL_W-1:0] refl,
                                           input logic [lpsf_pkg::STAMP_W-1:0] stamp,
                                           input logic [lpsf_pkg::LINE_W-1:0] line,
                                           input logic [lpsf_pkg::TAG_W-1:0] tag);
        t_point_in p;
        p.frame_start = fs;
        p.pos_x       = x;
        p.pos_y       = y;
        p.pos_z       = z;
        p.refl        = refl;
        p.stamp       = stamp;
        p.line_idx    = line;
        p.tag         = tag;
        return p;
    endfunction

    // Mostly sensor-like magnitudes, sometimes the extremes or full-width noise
    function automatic logic signed [lpsf_pkg::COORD_W-1:0] rand_coord();
        logic signed [lpsf_pkg::COORD_W-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 15))
            0: return {1'b1, {(lpsf_pkg::COORD_W-1){1'b0}}};
            1: return {1'b0, {(lpsf_pkg::COORD_W-1){1'b1}}};
            2: return '0;
            3: return v >>> $urandom_range(0, 31);
            default: return v >>> $urandom_range(6, 18);
        endcase
    endfunction

    function automatic t_point_in rand_point(input bit fs);
        t_point_in p;
        bit        noise;
        p.frame_start = fs;
        p.refl        = lpsf_pkg::REFL_W'($urandom());
        if (!fs && $urandom_range(0, 7) == 0) begin
            p.pos_x = last_pt.pos_x;
            p.pos_y = last_pt.pos_y;
            p.pos_z = last_pt.pos_z;
        end else begin
            p.pos_x = rand_coord();
            p.pos_y = rand_coord();
            p.pos_z = rand_coord();
        end
        if (fs)
            p.stamp = stamp_now;
        else case ($urandom_range(0, 15))
            0: p.stamp = {$urandom(), $urandom()};
            1: p.stamp = stamp_now - $urandom_range(1, 1000);
            2: p.stamp = stamp_now + 64'h1_0000_0000 + $urandom();
            default: p.stamp = stamp_now + $urandom_range(0, 100000);
        endcase
        noise = ($urandom_range(0, 6) == 0);
        if (!noise && cfg_lines != '0)
            p.line_idx = lpsf_pkg::LINE_W'($urandom_range(0, cfg_lines - 1));
        else
            p.line_idx = lpsf_pkg::LINE_W'($urandom());
        p.tag = lpsf_pkg::TAG_W'($urandom());
        if (!noise)
            p.tag[5] = 1'b0;
        last_pt = p;
        return p;
    endfunction

    // Hold until every point has been transferred and every result checked
    task automatic wait_drained();
        int unsigned waited;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (!(pending.size() == 0 && !tx_holding && kept_points.size() == 0)
                   && waited < DRAIN_LIMIT);
        if (waited >= DRAIN_LIMIT) begin
            $error("drain stuck: %0d points still expected", kept_points.size());
            n_errors++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input lpsf_pkg::t_cfg_idx idx,
                             input logic [lpsf_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            lpsf_pkg::CFG_MIN_RANGE:  cfg_min   = data;
            lpsf_pkg::CFG_MAX_RANGE:  cfg_max   = data;
            lpsf_pkg::CFG_DECIMATION: cfg_decim = data[lpsf_pkg::CNT_W-1:0];
            lpsf_pkg::CFG_LINE_COUNT: cfg_lines = data[lpsf_pkg::LINE_W-1:0];
        endcase
    endtask

    // Write all four registers; the upper bits of the byte registers carry junk
    task automatic set_config(input logic [lpsf_pkg::RANGE_W-1:0] min_r, max_r,
                              input logic [lpsf_pkg::CNT_W-1:0] dec,
                              input logic [lpsf_pkg::LINE_W-1:0] lines);
        logic [lpsf_pkg::CFG_DATA_W-1:0] data;
        write_reg(lpsf_pkg::CFG_MIN_RANGE, min_r);
        write_reg(lpsf_pkg::CFG_MAX_RANGE, max_r);
        data = lpsf_pkg::CFG_DATA_W'($urandom());
        data[lpsf_pkg::CNT_W-1:0] = dec;
        write_reg(lpsf_pkg::CFG_DECIMATION, data);
        data = lpsf_pkg::CFG_DATA_W'($urandom());
        data[lpsf_pkg::LINE_W-1:0] = lines;
        write_reg(lpsf_pkg::CFG_LINE_COUNT, data);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Queue frames of random points; pause the sender halfway until all results are in
    task automatic run_phase(input int n_items, input bit long_hold);
        int done;
        int npts;
        bit paused;
        done   = 0;
        paused = 1'b0;
        if (long_hold)
            long_hold_req++;
        while (done < n_items) begin
            npts = $urandom_range(0, 30);
            if ($urandom_range(0, 7) == 0)
                stamp_now = {$urandom(), $urandom()};
            else
                stamp_now = stamp_now + $urandom_range(0, 1 << 24);
            queue_point(rand_point(1'b1));
            repeat (npts) queue_point(rand_point(1'b0));
            done += npts + 1;
            if (!paused && done >= n_items / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        wait_drained();
    endtask

    initial begin
        logic [lpsf_pkg::RANGE_W-1:0] r;
        logic signed [lpsf_pkg::COORD_W-1:0] at_min, at_max, c_lo, c_hi;
        at_min = lpsf_pkg::COORD_W'(lpsf_pkg::MIN_RANGE_RST);
        at_max = lpsf_pkg::COORD_W'(lpsf_pkg::MAX_RANGE_RST);
        c_lo   = {1'b1, {(lpsf_pkg::COORD_W-1){1'b0}}};
        c_hi   = {1'b0, {(lpsf_pkg::COORD_W-1){1'b1}}};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: decimation 2, six lines, 0.5 m to 300 m
        // no frame start yet, so the time base is zero
        queue_point(mk_point(1'b0, 32'sh10000, 0, 0, 8'h00, 64'd1000, 8'd0, 8'h00));
        queue_point(mk_point(1'b0, 32'sh10000, 0, 0, 8'hFF, 64'd1000, 8'd5, 8'hCF));
        queue_point(mk_point(1'b1, 0, 0, 0, 8'h00, 64'h1_0000_0000, 8'd0, 8'h00));
        // exactly at the minimum range
        queue_point(mk_point(1'b0, at_min, 0, 0, 8'h07, 64'h1_0000_0010, 8'd1, 8'h10));
        queue_point(mk_point(1'b0, at_min, 0, 0, 8'h07, 64'h1_0000_0010, 8'd1, 8'h10));
        // line and tag rejects
        queue_point(mk_point(1'b0, 32'sh20000, 0, 0, 8'h01, 64'h1_0000_0020, 8'd6, 8'h00));
        queue_point(mk_point(1'b0, 32'sh20000, 0, 0, 8'h01, 64'h1_0000_0020, 8'd0, 8'h20));
        queue_point(mk_point(1'b0, 32'sh20000, 0, 0, 8'h01, 64'h1_0000_0020, 8'd0, 8'h30));
        queue_point(mk_point(1'b0, 32'sh20000, 0, 0, 8'h01, 64'h1_0000_0020, 8'd255, 8'hFF));
        // just below the window's lower edge is out
        queue_point(mk_point(1'b0, at_min - 1, 0, 0, 8'h02, 64'h1_0000_0030, 8'd2, 8'h00));
        queue_point(mk_point(1'b0, at_min - 1, 0, 0, 8'h02, 64'h1_0000_0030, 8'd2, 8'h00));
        // exactly at the maximum range, stamp before the base
        queue_point(mk_point(1'b0, 0, at_max, 0, 8'h03, 64'd5, 8'd3, 8'h10));
        queue_point(mk_point(1'b0, 0, at_max, 0, 8'h03, 64'd0, 8'd3, 8'h10));
        queue_point(mk_point(1'b0, 0, 0, at_max + 1, 8'h04, 64'd7, 8'd4, 8'h00));
        queue_point(mk_point(1'b0, 0, 0, at_max + 1, 8'h04, 64'd7, 8'd4, 8'h00));
        // most negative coordinates, then an offset that saturates
        queue_point(mk_point(1'b0, c_lo, c_lo, c_lo, 8'h05, '1, 8'd0, 8'h00));
        queue_point(mk_point(1'b0, c_lo, c_lo, c_lo, 8'h05, '1, 8'd0, 8'h00));
        queue_point(mk_point(1'b0, -32'sh10000, -32'sh10000, 32'sh10000, 8'h06, '1,
                             8'd1, 8'h0F));
        queue_point(mk_point(1'b0, -32'sh10000, -32'sh10000, 32'sh10000, 8'h06, '1,
                             8'd1, 8'h0F));
        wait_drained();

        // Open window, every point: duplicate of the cleared slot, repeats, largest point
        set_config('0, '1, 8'd1, 8'd255);
        queue_point(mk_point(1'b1, 0, 0, 0, 8'h00, 64'd0, 8'd0, 8'h00));
        queue_point(mk_point(1'b0, 0, 0, 0, 8'h11, 64'd3, 8'd0, 8'h00));
        queue_point(mk_point(1'b0, 1, 2, 3, 8'h12, 64'd4, 8'd254, 8'h10));
        queue_point(mk_point(1'b0, 1, 2, 3, 8'h13, 64'd5, 8'd254, 8'h10));
        queue_point(mk_point(1'b0, 1, 2, 4, 8'h14, 64'd6, 8'd254, 8'h10));
        queue_point(mk_point(1'b0, c_hi, c_hi, c_hi, 8'h15, 64'd7, 8'd0, 8'h00));
        wait_drained();

        // Random frames over several settings, extremes among them
        set_config(lpsf_pkg::MIN_RANGE_RST, lpsf_pkg::MAX_RANGE_RST,
                   lpsf_pkg::DECIMATION_RST, lpsf_pkg::LINE_COUNT_RST);
        run_phase(130, 1'b0);
        set_config('0, '1, 8'd1, 8'd255);
        run_phase(130, 1'b1);
        set_config('1, '1, 8'd255, 8'd1);
        run_phase(40, 1'b0);
        set_config(lpsf_pkg::MAX_RANGE_RST, lpsf_pkg::MIN_RANGE_RST, 8'd3, 8'd8);
        run_phase(40, 1'b0);
        set_config('0, 31'h4000_0000, 8'd0, 8'd200);
        run_phase(100, 1'b0);
        set_config(31'h1_0000, '1, 8'd4, 8'd0);
        run_phase(40, 1'b0);
        repeat (3) begin
            r = lpsf_pkg::RANGE_W'($urandom_range(0, 1 << 24));
            set_config(r, lpsf_pkg::RANGE_W'(r + $urandom_range(0, 1 << 26)),
                       lpsf_pkg::CNT_W'($urandom_range(1, 4)),
                       lpsf_pkg::LINE_W'($urandom_range(1, 255)));
            run_phase(100, 1'b0);
        end

        if (n_errors == 0)
            $display("[lidar_point_stream_filter] OK");
        else
            $display("[lidar_point_stream_filter] ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[lidar_point_stream_filter] ERROR");
        $finish;
    end

endmodule
